>>> hw/rtl/sdmct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmct_pkg
// Shared types and constants of the split direct-mapped cache tag block.
// ----------------------------------------------------------------------------
package sdmct_pkg;

    localparam int ADDR_W   = 32;
    localparam int MAX_SETS = 1024;
    localparam int SET_W    = $clog2(MAX_SETS);
    localparam int TAG_W    = ADDR_W;
    localparam int LINE_W   = TAG_W + 1;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 4;
    localparam int SHAMT_W  = CFG_W + 1;
    localparam int ACT_W    = 2;

    // APB map: register i at byte address 4*i
    localparam int APB_DW      = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_SEL_LSB = 2;
    localparam int REG_SEL_W   = PADDR_W - REG_SEL_LSB;

    localparam logic [REG_SEL_W-1:0] REG_INDEX_BITS  = REG_SEL_W'(0);
    localparam logic [REG_SEL_W-1:0] REG_OFFSET_BITS = REG_SEL_W'(1);

    localparam logic [CFG_W-1:0] INDEX_BITS_RST  = CFG_W'(8);
    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = CFG_W'(4);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // upper bit of the access kind selects the instruction side
    localparam int ACT_INST_BIT = 1;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ADDR_W-1:0] address;
    } t_access;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] hits_so_far;
        logic [CNT_W-1:0] misses_so_far;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] index_bits;
        logic [CFG_W-1:0] offset_bits;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic load;
        logic lookup;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_status;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

endpackage

>>> hw/rtl/sdmct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sdmct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/sdmct_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmct_regs
// APB configuration registers: index width and offset width.
// ----------------------------------------------------------------------------
module sdmct_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sdmct_pkg::PADDR_W-1:0]  paddr,
    input  logic [sdmct_pkg::APB_DW-1:0]   pwdata,
    output logic [sdmct_pkg::APB_DW-1:0]   prdata,
    output logic                           pready,
    output sdmct_pkg::t_cfg                o_cfg
);
    import sdmct_pkg::*;

    logic [REG_SEL_W-1:0] reg_sel;
    logic                 wr_en;
    t_cfg                 r_cfg;
    t_cfg                 n_cfg;

    assign reg_sel = paddr[PADDR_W-1:REG_SEL_LSB];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_INDEX_BITS:  n_cfg.index_bits  = pwdata[CFG_W-1:0];
                REG_OFFSET_BITS: n_cfg.offset_bits = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_INDEX_BITS:  prdata = APB_DW'(r_cfg.index_bits);
            REG_OFFSET_BITS: prdata = APB_DW'(r_cfg.offset_bits);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.index_bits  <= INDEX_BITS_RST;
            r_cfg.offset_bits <= OFFSET_BITS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/sdmct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmct_ctrl
// Sequencer: clearing pass after reset, then lookup and update per access.
// ----------------------------------------------------------------------------
module sdmct_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  sdmct_pkg::t_dp_status i_status,
    output sdmct_pkg::t_dp_cmd    o_cmd,
    output logic                  o_busy
);
    import sdmct_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOKUP = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> hw/rtl/sdmct_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmct_dp
// Address split, tag directories, hit/miss counters and result register.
// ----------------------------------------------------------------------------
module sdmct_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sdmct_pkg::t_cfg       i_cfg,
    input  sdmct_pkg::t_access    i_access,
    input  sdmct_pkg::t_dp_cmd    i_cmd,
    output sdmct_pkg::t_dp_status o_status,
    output sdmct_pkg::t_result    o_result,
    output logic                  o_done
);
    import sdmct_pkg::*;

    // split of the incoming address
    logic [ADDR_W-1:0]  above_offset;
    logic [ADDR_W-1:0]  idx_mask;
    logic [SHAMT_W-1:0] tag_shamt;
    logic [SET_W-1:0]   set_in;
    logic [TAG_W-1:0]   tag_in;

    // captured access
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_inst;

    // clearing pass
    logic [SET_W-1:0] r_clr_addr;

    // directories
    logic              d_we;
    logic              i_we;
    logic [SET_W-1:0]  waddr;
    logic [LINE_W-1:0] wdata;
    logic [LINE_W-1:0] d_rdata;
    logic [LINE_W-1:0] i_rdata;
    logic [LINE_W-1:0] line;
    logic              hit;

    // counters
    logic [CNT_W-1:0] r_d_hits;
    logic [CNT_W-1:0] r_d_misses;
    logic [CNT_W-1:0] r_i_hits;
    logic [CNT_W-1:0] r_i_misses;
    logic [CNT_W-1:0] n_hits;
    logic [CNT_W-1:0] n_misses;

    t_result r_result;
    logic    r_done;

    assign above_offset = i_access.address >> i_cfg.offset_bits;
    assign idx_mask     = (ADDR_W'(1) << i_cfg.index_bits) - ADDR_W'(1);
    assign set_in       = SET_W'(above_offset & idx_mask);
    assign tag_shamt    = SHAMT_W'(i_cfg.offset_bits) + SHAMT_W'(i_cfg.index_bits);
    assign tag_in       = TAG_W'(i_access.address >> tag_shamt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set  <= set_in;
            r_tag  <= tag_in;
            r_inst <= i_access.action[ACT_INST_BIT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + SET_W'(1);
        end
    end

    assign o_status.clear_last = (r_clr_addr == SET_W'(MAX_SETS - 1));

    // line = {valid, tag}
    assign line = r_inst ? i_rdata : d_rdata;
    assign hit  = line[LINE_W-1] && (line[TAG_W-1:0] == r_tag);

    assign d_we  = i_cmd.clear | (i_cmd.update & ~hit & ~r_inst);
    assign i_we  = i_cmd.clear | (i_cmd.update & ~hit & r_inst);
    assign waddr = i_cmd.clear ? r_clr_addr : r_set;
    assign wdata = i_cmd.clear ? '0 : {1'b1, r_tag};

    sdmct_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_SETS)
    ) u_data_dir (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.lookup),
        .i_raddr (r_set),
        .o_rdata (d_rdata)
    );

    sdmct_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_SETS)
    ) u_inst_dir (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.lookup),
        .i_raddr (r_set),
        .o_rdata (i_rdata)
    );

    always_comb begin
        n_hits   = r_inst ? r_i_hits : r_d_hits;
        n_misses = r_inst ? r_i_misses : r_d_misses;
        if (hit) begin
            n_hits = sat_inc(n_hits);
        end else begin
            n_misses = sat_inc(n_misses);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_hits   <= '0;
            r_d_misses <= '0;
            r_i_hits   <= '0;
            r_i_misses <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
            if (i_cmd.update) begin
                if (r_inst) begin
                    r_i_hits   <= n_hits;
                    r_i_misses <= n_misses;
                end else begin
                    r_d_hits   <= n_hits;
                    r_d_misses <= n_misses;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_result.hit           <= hit;
            r_result.hits_so_far   <= n_hits;
            r_result.misses_so_far <= n_misses;
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

>>> hw/rtl/split_direct_mapped_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_direct_mapped_cache_tags
// Tag directories of a split (data / instruction) direct-mapped cache.
// ----------------------------------------------------------------------------
// Usage:
//   Access channel: drive i_cmd and raise start; the beat is taken at a
//   clock edge with start high and busy low. Access kinds with the upper
//   bit set go to the instruction directory, the others to the data one.
//   Result channel: o_done pulses for one cycle with o_result holding hit
//   and the running hit/miss counts of the accessed side (saturating).
//   The receiver cannot stall; sample the result in the o_done cycle.
//   Each access runs through directory RAM read (registered), compare and
//   tag write, with busy high throughout; then the result is shown while
//   the next beat may be taken. busy drops in the cycle the result is
//   shown.
//   Reset: counters clear and configuration returns to index_bits 8,
//   offset_bits 4; a clearing pass then walks all 1024 sets of both
//   directories, one set a cycle, holding busy high throughout.
//   APB: register 0 (0x0) index_bits, register 1 (0x4) offset_bits, low
//   four data bits; write only while the block is idle. pready is tied
//   high.
// ----------------------------------------------------------------------------
module split_direct_mapped_cache_tags (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sdmct_pkg::t_access            i_cmd,
    output logic                          o_done,
    output sdmct_pkg::t_result            o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdmct_pkg::PADDR_W-1:0] paddr,
    input  logic [sdmct_pkg::APB_DW-1:0]  pwdata,
    output logic [sdmct_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import sdmct_pkg::*;

    t_cfg       cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // configuration registers
    sdmct_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: clear pass, then capture / lookup / update per beat
    sdmct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // address split, directories, counters
    sdmct_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_access (i_cmd),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_result (o_result),
        .o_done   (o_done)
    );

    // every accepted beat yields its result on o_done
    a_accept_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("result missing three cycles after accept");

    // a result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // the block is free again while the result is shown
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy while result is shown");

    // a result beat is never directly followed by another
    a_single_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("results closer than one access period");

endmodule

>>> tb/cache_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_access_checker
// Watches the access, result and APB channels of the split cache tag block.
// Keeps its own copy of both tag directories, works out the hit flag and
// running counts of each access, and compares every result against them.
// ----------------------------------------------------------------------------
module cache_access_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  sdmct_pkg::t_access            i_cmd,
    input  logic                          i_done,
    input  sdmct_pkg::t_result            i_result,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [sdmct_pkg::PADDR_W-1:0] i_paddr,
    input  logic [sdmct_pkg::APB_DW-1:0]  i_pwdata,
    output int                            o_pending,
    output int                            o_fail_count
);
    import sdmct_pkg::*;

    // Directory copy: index 0 is the data side, index 1 the instruction side
    bit               line_valid [2][MAX_SETS];
    logic [TAG_W-1:0] line_tag   [2][MAX_SETS];
    logic [CNT_W-1:0] hit_total  [2];
    logic [CNT_W-1:0] miss_total [2];
    logic [CFG_W-1:0] cur_index_bits;
    logic [CFG_W-1:0] cur_offset_bits;

    t_result pending_lookups[$];
    int      fail_total = 0;

    function automatic t_result lookup_directory(input t_access acc);
        logic [63:0]      addr;
        logic [63:0]      above_offset;
        logic [63:0]      index_field;
        logic [63:0]      tag;
        logic [SET_W-1:0] set_sel;
        logic             side;
        int unsigned      ob;
        int unsigned      ib;
        t_result          res;
        ob           = cur_offset_bits;
        ib           = cur_index_bits;
        addr         = 64'(acc.address);
        above_offset = (ob >= ADDR_W) ? 64'd0 : addr >> ob;
        index_field  = above_offset & ((64'd1 << ib) - 64'd1);
        tag          = (ob + ib >= ADDR_W) ? 64'd0 : addr >> (ob + ib);
        // index bits beyond the table alias onto the low sets
        set_sel      = index_field[SET_W-1:0];
        side         = acc.action[ACT_INST_BIT];
        res.hit      = line_valid[side][set_sel] &&
                       (line_tag[side][set_sel] == tag[TAG_W-1:0]);
        if (res.hit) begin
            if (hit_total[side] != CNT_MAX) hit_total[side] = hit_total[side] + CNT_W'(1);
        end else begin
            line_tag[side][set_sel]   = tag[TAG_W-1:0];
            line_valid[side][set_sel] = 1'b1;
            if (miss_total[side] != CNT_MAX) miss_total[side] = miss_total[side] + CNT_W'(1);
        end
        res.hits_so_far   = hit_total[side];
        res.misses_so_far = miss_total[side];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < 2; s++) begin
                for (int k = 0; k < MAX_SETS; k++) begin
                    line_valid[s][k] = 1'b0;
                    line_tag[s][k]   = '0;
                end
                hit_total[s]  = '0;
                miss_total[s] = '0;
            end
            cur_index_bits  = INDEX_BITS_RST;
            cur_offset_bits = OFFSET_BITS_RST;
            pending_lookups.delete();
        end else begin
            // results first: a beat accepted at this edge lands later
            if (i_done) begin
                if (pending_lookups.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got hit %0d hits %0d %s %0d",
                             $time, i_result.hit, i_result.hits_so_far, "misses",
                             i_result.misses_so_far);
                    fail_total++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (i_result.hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0d, got %0d",
                                 $time, want.hit, i_result.hit);
                        fail_total++;
                    end
                    if (i_result.hits_so_far !== want.hits_so_far) begin
                        $display("%0t: hits_so_far mismatch, expected %0d, got %0d",
                                 $time, want.hits_so_far, i_result.hits_so_far);
                        fail_total++;
                    end
                    if (i_result.misses_so_far !== want.misses_so_far) begin
                        $display("%0t: misses_so_far mismatch, expected %0d, got %0d",
                                 $time, want.misses_so_far, i_result.misses_so_far);
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy) pending_lookups.push_back(lookup_directory(i_cmd));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[PADDR_W-1:REG_SEL_LSB] == REG_INDEX_BITS)
                    cur_index_bits = i_pwdata[CFG_W-1:0];
                else if (i_paddr[PADDR_W-1:REG_SEL_LSB] == REG_OFFSET_BITS)
                    cur_offset_bits = i_pwdata[CFG_W-1:0];
            end
        end
        o_pending    = pending_lookups.size();
        o_fail_count = fail_total;
    end

endmodule

>>> tb/tb_split_direct_mapped_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_split_direct_mapped_cache_tags
// Drives accesses and APB setup into the split cache tag block. A short
// directed run covers both directories, the unused access kind, address
// extremes and line conflicts; then random phases walk through several
// index/offset splits, extremes among them, with traffic built around a
// small working set so hits, conflicts and evictions all occur. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_split_direct_mapped_cache_tags;
    import sdmct_pkg::*;

    // Access kinds; the upper bit routes to the instruction directory
    localparam logic [ACT_W-1:0] ACT_DATA_READ  = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_DATA_WRITE = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_INST_FETCH = ACT_W'(2);
    localparam logic [ACT_W-1:0] ACT_UNUSED     = ACT_W'(3);

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int POOL_SIZE       = 16;
    localparam int TAIL_CYCLES     = 8;
    localparam int CYCLE_LIMIT     = 200000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_access               i_cmd;
    logic                  o_done;
    t_result               o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int                    pending_count;
    int                    fail_count;
    int                    cycle_count = 0;

    // Split in force, mirrored here to shape addresses
    logic [CFG_W-1:0]      set_index_bits;
    logic [CFG_W-1:0]      set_offset_bits;
    logic [ADDR_W-1:0]     working_set [POOL_SIZE];
    int                    burst_left;

    split_direct_mapped_cache_tags dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cache_access_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending_count),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Watchdog: covers the clearing pass plus the slowest legal run many times
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Hold until the block is idle and every result beat is in; end at an edge.
    task automatic wait_idle();
        @(negedge i_clk);
        while (busy || pending_count != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Write one register: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [REG_SEL_W-1:0] reg_sel,
                             input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] rnd;
        rnd     = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, {REG_SEL_LSB{1'b0}}};
        // upper data bits are don't-care; randomize them
        pwdata  <= {rnd[APB_DW-1:CFG_W], value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send one beat inside the burst pattern; returns at the accept edge.
    task automatic send_access(input t_access acc);
        int gap;
        if (burst_left == 0) begin
            // a quarter of the bursts run long with no gap at all
            if ($urandom_range(0, 3) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(20, 40);
            end else begin
                gap        = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 8);
            end
            if (gap > 0) begin
                start <= 1'b0;
                i_cmd <= t_access'({ACT_W'($urandom), ADDR_W'($urandom)});  // junk while idle
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= acc;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Build an address around the working set: repeats, conflicts, fresh lines.
    function automatic logic [ADDR_W-1:0] next_address();
        int                unsigned pick;
        int                unsigned roll;
        int                unsigned split;
        logic [ADDR_W-1:0] offset_mask;
        logic [ADDR_W-1:0] addr;
        pick  = $urandom_range(0, POOL_SIZE - 1);
        roll  = $urandom_range(0, 99);
        split = set_offset_bits + set_index_bits;
        offset_mask = (set_offset_bits >= ADDR_W) ? '1 : ((ADDR_W'(1) << set_offset_bits) - 1'b1);
        if (roll < 50) begin
            // same line, any byte within it
            addr = (working_set[pick] & ~offset_mask) | ($urandom & offset_mask);
        end else if (roll < 75 && split < ADDR_W) begin
            // same set, different tag: evict
            addr = working_set[pick] ^ (ADDR_W'($urandom_range(1, 255)) << split);
            working_set[pick] = addr;
        end else if (roll < 80) begin
            addr = ($urandom_range(0, 1) == 0) ? '0 : '1;
        end else begin
            addr = $urandom;
            working_set[pick] = addr;
        end
        return addr;
    endfunction

    initial begin
        logic [CFG_W-1:0] phase_index [NUM_PHASES];
        logic [CFG_W-1:0] phase_offset [NUM_PHASES];
        t_access          acc;

        phase_index  = '{4'd8, 4'd0, 4'd10, 4'd15, 4'd12, 4'd3,  4'd15, 4'd1, 4'd0};
        phase_offset = '{4'd4, 4'd0, 4'd12, 4'd15, 4'd2,  4'd15, 4'd0,  4'd6, 4'd0};
        // last phase takes a random split
        phase_index[NUM_PHASES-1]  = $urandom_range(0, 15);
        phase_offset[NUM_PHASES-1] = $urandom_range(0, 15);

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        burst_left  = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold through the clearing pass
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // phase 0 runs at the reset split; write every register later
            if (p > 0) begin
                write_reg(REG_INDEX_BITS, phase_index[p]);
                write_reg(REG_OFFSET_BITS, phase_offset[p]);
            end
            set_index_bits  = phase_index[p];
            set_offset_bits = phase_offset[p];
            for (int k = 0; k < POOL_SIZE; k++) working_set[k] = $urandom;

            if (p == 0) begin
                // 256 sets of 16-byte lines
                send_access(t_access'{ACT_DATA_READ,  32'h0000_0000});  // cold miss
                send_access(t_access'{ACT_DATA_READ,  32'h0000_0000});  // hit
                send_access(t_access'{ACT_DATA_WRITE, 32'h0000_000F});  // hit, same line
                send_access(t_access'{ACT_INST_FETCH, 32'h0000_0000});  // other side misses
                send_access(t_access'{ACT_UNUSED,     32'h0000_0004});  // unused kind -> inst
                send_access(t_access'{ACT_DATA_READ,  32'hFFFF_FFFF});
                send_access(t_access'{ACT_DATA_WRITE, 32'hFFFF_FFF0});
                send_access(t_access'{ACT_INST_FETCH, 32'hFFFF_FFFF});
                send_access(t_access'{ACT_DATA_READ,  32'hFFFF_F000});  // evict set 0
                send_access(t_access'{ACT_DATA_READ,  32'h0000_0000});  // miss again
                send_access(t_access'{ACT_INST_FETCH, 32'h0000_0010});
                send_access(t_access'{ACT_INST_FETCH, 32'h0000_001F});
                send_access(t_access'{ACT_DATA_READ,  32'hAAAA_AAAA});
                send_access(t_access'{ACT_DATA_READ,  32'h5555_5555});
                send_access(t_access'{ACT_INST_FETCH, 32'hAAAA_AAAA});
                send_access(t_access'{ACT_DATA_WRITE, 32'h5555_555A});
                send_access(t_access'{ACT_UNUSED,     32'h5555_5555});
                send_access(t_access'{ACT_DATA_READ,  32'h0000_0FF0});  // top set
                send_access(t_access'{ACT_DATA_READ,  32'h0000_1FF0});  // conflict there
                send_access(t_access'{ACT_DATA_READ,  32'h0000_0FF0});
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                acc.action  = ACT_W'($urandom_range(0, 3));
                acc.address = next_address();
                send_access(acc);
            end
            start <= 1'b0;
            burst_left = 0;
            wait_idle();
        end

        // drop the stimulus and let any stray beat show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
